>>> src/assert_macros.svh
// Assertion macros for the checker file.
// Each macro expects clk and rst to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define HRF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define HRF_ASSERT_IMPL(lbl, cond, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) else $error(msg);

`endif

>>> src/hrf_pkg.sv
// Types, codes and byte helpers for the HTTP request framer.
// No dependencies; used by every framer module.
`default_nettype none

package hrf_pkg;

  // Parser phases
  typedef enum logic [2:0] {
    PH_LINE,
    PH_HDR,
    PH_BODY,
    PH_DONE,
    PH_ERR
  } phase_t;

  // Section codes
  localparam logic [2:0] SEC_NONE    = 3'd0;
  localparam logic [2:0] SEC_METHOD  = 3'd1;
  localparam logic [2:0] SEC_NAME    = 3'd4;
  localparam logic [2:0] SEC_VALUE   = 3'd5;
  localparam logic [2:0] SEC_BODY    = 3'd6;
  localparam logic [2:0] SEC_DELIM   = 3'd7;

  // Event codes
  localparam logic [2:0] EV_NONE     = 3'd0;
  localparam logic [2:0] EV_REQ_OK   = 3'd1;
  localparam logic [2:0] EV_HDR_OK   = 3'd2;
  localparam logic [2:0] EV_HDRS_END = 3'd3;
  localparam logic [2:0] EV_COMPLETE = 3'd4;
  localparam logic [2:0] EV_ERROR    = 3'd5;

  // Status codes
  localparam logic [1:0] ST_INCOMPLETE = 2'd0;
  localparam logic [1:0] ST_COMPLETE   = 2'd1;
  localparam logic [1:0] ST_ERROR      = 2'd2;

  // Value number substates
  localparam logic [2:0] VS_IDLE   = 3'd0;
  localparam logic [2:0] VS_START  = 3'd1;
  localparam logic [2:0] VS_SIGN   = 3'd2;
  localparam logic [2:0] VS_DIGITS = 3'd3;
  localparam logic [2:0] VS_END    = 3'd4;
  localparam logic [2:0] VS_BAD    = 3'd5;

  // Header name match
  localparam logic [4:0] MATCH_LEN  = 5'd14;
  localparam logic [4:0] MATCH_FAIL = 5'd31;

  // Characters
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;

  localparam logic [31:0] MAX_BODY_RESET = 32'd1048576;
  localparam int unsigned Q_DEPTH = 4;

  typedef struct packed {
    logic       mode;
    logic [7:0] data_byte;
  } in_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic [2:0]  section;
    logic [2:0]  event_res;
    logic [1:0]  status;
    logic [31:0] body_length;
    logic        last;
  } res_t;

  // Results handed from the front to the queue in one cycle
  typedef struct packed {
    logic [1:0] count;
    res_t       first;
    res_t       second;
  } push_t;

  typedef struct packed {
    phase_t     phase;
    logic       cr_held;
    logic [1:0] spaces_seen;
    logic       line_empty;
    logic       colon_seen;
    logic [4:0] name_match_pos;
    logic [2:0] value_substate;
    logic       value_negative;
  } ctl_st_t;

  localparam ctl_st_t ST_RESET = '{
    phase: PH_LINE, cr_held: 1'b0, spaces_seen: 2'd0, line_empty: 1'b1,
    colon_seen: 1'b0, name_match_pos: 5'd0, value_substate: VS_IDLE,
    value_negative: 1'b0
  };

  // Outcome of one ordinary line byte
  typedef struct packed {
    ctl_st_t    st;
    logic [7:0] ob;
    logic [2:0] sec;
    logic       dig_en;
    logic [3:0] dig;
  } ct_t;

  function automatic logic [7:0] cl_char(input logic [4:0] pos);
    logic [7:0] c;
    begin
      case (pos)
        5'd0:    c = 8'h63; // c
        5'd1:    c = 8'h6F; // o
        5'd2:    c = 8'h6E; // n
        5'd3:    c = 8'h74; // t
        5'd4:    c = 8'h65; // e
        5'd5:    c = 8'h6E; // n
        5'd6:    c = 8'h74; // t
        5'd7:    c = 8'h2D; // -
        5'd8:    c = 8'h6C; // l
        5'd9:    c = 8'h65; // e
        5'd10:   c = 8'h6E; // n
        5'd11:   c = 8'h67; // g
        5'd12:   c = 8'h74; // t
        5'd13:   c = 8'h68; // h
        default: c = 8'h00;
      endcase
      return c;
    end
  endfunction

  function automatic ctl_st_t clear_line(input ctl_st_t st);
    ctl_st_t r;
    begin
      r = st;
      r.line_empty     = 1'b1;
      r.colon_seen     = 1'b0;
      r.name_match_pos = 5'd0;
      r.value_substate = VS_IDLE;
      r.value_negative = 1'b0;
      return r;
    end
  endfunction

  // Classify one ordinary byte of the request line or a header line
  function automatic ct_t content_step(input ctl_st_t st, input logic [7:0] b);
    ct_t        r;
    logic [7:0] low;
    logic       ws;
    logic       dig;
    logic [2:0] vs;
    begin
      r        = '0;
      r.st     = st;
      r.ob     = b;
      r.sec    = SEC_NONE;
      r.dig_en = 1'b0;
      r.dig    = b[3:0];
      ws  = (b == CH_SPACE) || (b >= 8'd9 && b <= 8'd13);
      dig = (b >= 8'h30) && (b <= 8'h39);
      low = (b >= 8'h41 && b <= 8'h5A) ? b + 8'd32 : b;
      vs  = (st.value_substate == VS_IDLE) ? VS_START : st.value_substate;
      if (st.phase == PH_LINE) begin
        if (b == CH_SPACE && st.spaces_seen < 2'd2) begin
          r.st.spaces_seen = st.spaces_seen + 2'd1;
          r.sec = SEC_DELIM;
        end else begin
          r.sec = SEC_METHOD + 3'(st.spaces_seen);
        end
      end else begin
        r.st.line_empty = 1'b0;
        if (!st.colon_seen) begin
          if (b == CH_COLON) begin
            r.st.colon_seen = 1'b1;
            r.sec = SEC_DELIM;
          end else begin
            if (st.name_match_pos < MATCH_LEN && low == cl_char(st.name_match_pos)) begin
              r.st.name_match_pos = st.name_match_pos + 5'd1;
            end else begin
              r.st.name_match_pos = MATCH_FAIL;
            end
            r.ob  = low;
            r.sec = SEC_NAME;
          end
        end else if (st.value_substate == VS_IDLE && b == CH_SPACE) begin
          r.sec = SEC_DELIM;
        end else begin
          r.sec = SEC_VALUE;
          r.st.value_substate = vs;
          unique case (vs)
            VS_START: begin
              if (ws) begin
                r.st.value_substate = VS_START;
              end else if (b == CH_PLUS || b == CH_MINUS) begin
                r.st.value_negative = (b == CH_MINUS);
                r.st.value_substate = VS_SIGN;
              end else if (dig) begin
                r.dig_en = 1'b1;
                r.st.value_substate = VS_DIGITS;
              end else begin
                r.st.value_substate = VS_BAD;
              end
            end
            VS_SIGN: begin
              if (dig) begin
                r.dig_en = 1'b1;
                r.st.value_substate = VS_DIGITS;
              end else begin
                r.st.value_substate = VS_BAD;
              end
            end
            VS_DIGITS: begin
              if (dig) begin
                r.dig_en = 1'b1;
              end else begin
                r.st.value_substate = VS_END;
              end
            end
            default: begin
              r.st.value_substate = vs;
            end
          endcase
        end
      end
      return r;
    end
  endfunction

  function automatic res_t mk_res(input logic [7:0] b, input logic [2:0] sec,
                                  input logic [2:0] ev, input logic [1:0] st,
                                  input logic [31:0] blen);
    res_t r;
    begin
      r.out_byte    = b;
      r.section     = sec;
      r.event_res   = ev;
      r.status      = st;
      r.body_length = blen;
      r.last        = 1'b0;
      return r;
    end
  endfunction

endpackage

`default_nettype wire

>>> src/hrf_front.sv
// Front of the framer: accepts bytes, runs the parser state and forms results.
// Depends on hrf_pkg; pushes up to two results a cycle into hrf_queue.
`default_nettype none

module hrf_front #(
  parameter int LENGTH_BITS = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  hrf_pkg::in_t  in_data,
  input  logic          cfg_write,
  input  logic [31:0]   cfg_data,
  input  logic          room,
  output hrf_pkg::push_t push
);
  import hrf_pkg::*;

  localparam int AW = LENGTH_BITS + 1;
  localparam int PW = LENGTH_BITS + 5;
  localparam int CW = (LENGTH_BITS > 32) ? LENGTH_BITS : 32;

  ctl_st_t                st, st_next;
  logic [AW-1:0]          accum, accum_next;
  logic [LENGTH_BITS-1:0] chosen, chosen_next;
  logic                   chosen_invalid, chosen_invalid_next;
  logic [31:0]            remaining, remaining_next;
  logic [31:0]            max_body_size;

  logic       accept;
  logic [7:0] b;
  ct_t        c1, c2;
  logic       dig_en;
  logic [3:0] dig;
  logic [PW-1:0] prod, cap;
  logic [AW-1:0] accum_sat;
  logic [CW-1:0] chosen_ext;
  logic          too_long;
  logic          inv_new;
  logic          line_end;

  assign accept   = in_valid && room;
  assign in_stall = !room;
  assign b        = in_data.data_byte;
  assign line_end = st.cr_held && (b == CH_LF);

  // Classify the held CR (if any) first, then the new byte
  assign c1 = content_step(st, st.cr_held ? CH_CR : b);
  assign c2 = content_step(c1.st, b);

  // Accumulate one decimal digit, saturating at 2^LENGTH_BITS
  assign dig_en    = st.cr_held ? c2.dig_en : c1.dig_en;
  assign dig       = st.cr_held ? c2.dig : c1.dig;
  assign cap       = PW'(1) << LENGTH_BITS;
  assign prod      = PW'({accum, 3'b000}) + PW'({accum, 1'b0}) + PW'(dig);
  assign accum_sat = (prod > cap) ? cap[AW-1:0] : prod[AW-1:0];

  assign chosen_ext = CW'(chosen);
  assign too_long   = chosen_ext > CW'(max_body_size);
  assign inv_new    = !(st.value_substate == VS_DIGITS || st.value_substate == VS_END) ||
                      accum[LENGTH_BITS] || (st.value_negative && (accum != '0));

  // Next parser state
  always_comb begin
    st_next             = st;
    accum_next          = accum;
    chosen_next         = chosen;
    chosen_invalid_next = chosen_invalid;
    remaining_next      = remaining;
    if (accept) begin
      if (in_data.mode) begin
        st_next             = ST_RESET;
        accum_next          = '0;
        chosen_next         = '0;
        chosen_invalid_next = 1'b0;
        remaining_next      = '0;
      end else begin
        priority if (st.phase == PH_BODY) begin
          remaining_next = remaining - 32'd1;
          if (remaining == 32'd1) begin
            st_next.phase = PH_DONE;
          end
        end else if (st.phase == PH_DONE || st.phase == PH_ERR) begin
          st_next = st;
        end else if (line_end) begin
          st_next.cr_held = 1'b0;
          if (st.phase == PH_LINE) begin
            if (st.spaces_seen < 2'd2) begin
              st_next.phase = PH_ERR;
            end else begin
              st_next       = clear_line(st_next);
              st_next.phase = PH_HDR;
              accum_next    = '0;
            end
          end else if (st.line_empty) begin
            if (chosen_invalid || too_long) begin
              st_next.phase = PH_ERR;
            end else if (chosen == '0) begin
              st_next.phase = PH_DONE;
            end else begin
              st_next.phase  = PH_BODY;
              remaining_next = chosen_ext[31:0];
            end
          end else if (!st.colon_seen) begin
            st_next.phase = PH_ERR;
          end else begin
            if (st.name_match_pos == MATCH_LEN) begin
              chosen_invalid_next = inv_new;
              chosen_next         = inv_new ? '0 : accum[LENGTH_BITS-1:0];
            end
            st_next    = clear_line(st_next);
            accum_next = '0;
          end
        end else if (st.cr_held) begin
          if (b == CH_CR) begin
            st_next         = c1.st;
            st_next.cr_held = 1'b1;
          end else begin
            st_next         = c2.st;
            st_next.cr_held = 1'b0;
            if (dig_en) begin
              accum_next = accum_sat;
            end
          end
        end else if (b == CH_CR) begin
          st_next.cr_held = 1'b1;
        end else begin
          st_next = c1.st;
          if (dig_en) begin
            accum_next = accum_sat;
          end
        end
      end
    end
  end

  // Results of this byte
  always_comb begin
    push        = '0;
    push.first  = mk_res(8'd0, SEC_NONE, EV_NONE, ST_INCOMPLETE, 32'd0);
    push.second = mk_res(8'd0, SEC_NONE, EV_NONE, ST_INCOMPLETE, 32'd0);
    if (accept && !in_data.mode) begin
      priority if (st.phase == PH_BODY) begin
        push.count = 2'd1;
        push.first = (remaining == 32'd1) ?
                     mk_res(b, SEC_BODY, EV_COMPLETE, ST_COMPLETE, 32'd0) :
                     mk_res(b, SEC_BODY, EV_NONE, ST_INCOMPLETE, 32'd0);
      end else if (st.phase == PH_DONE) begin
        push.count = 2'd1;
        push.first = mk_res(8'd0, SEC_NONE, EV_NONE, ST_COMPLETE, 32'd0);
      end else if (st.phase == PH_ERR) begin
        push.count = 2'd1;
        push.first = mk_res(8'd0, SEC_NONE, EV_NONE, ST_ERROR, 32'd0);
      end else if (line_end) begin
        push.count = 2'd1;
        if (st.phase == PH_LINE) begin
          push.first = (st.spaces_seen < 2'd2) ?
                       mk_res(CH_LF, SEC_DELIM, EV_ERROR, ST_ERROR, 32'd0) :
                       mk_res(CH_LF, SEC_DELIM, EV_REQ_OK, ST_INCOMPLETE, 32'd0);
        end else if (st.line_empty) begin
          if (chosen_invalid || too_long) begin
            push.first = mk_res(CH_LF, SEC_DELIM, EV_ERROR, ST_ERROR, 32'd0);
          end else if (chosen == '0) begin
            push.count  = 2'd2;
            push.first  = mk_res(CH_LF, SEC_DELIM, EV_HDRS_END, ST_COMPLETE, 32'd0);
            push.second = mk_res(8'd0, SEC_NONE, EV_COMPLETE, ST_COMPLETE, 32'd0);
          end else begin
            push.first = mk_res(CH_LF, SEC_DELIM, EV_HDRS_END, ST_INCOMPLETE,
                                chosen_ext[31:0]);
          end
        end else if (!st.colon_seen) begin
          push.first = mk_res(CH_LF, SEC_DELIM, EV_ERROR, ST_ERROR, 32'd0);
        end else begin
          push.first = mk_res(CH_LF, SEC_DELIM, EV_HDR_OK, ST_INCOMPLETE, 32'd0);
        end
      end else if (st.cr_held) begin
        push.first = mk_res(c1.ob, c1.sec, EV_NONE, ST_INCOMPLETE, 32'd0);
        if (b == CH_CR) begin
          push.count = 2'd1;
        end else begin
          push.count  = 2'd2;
          push.second = mk_res(c2.ob, c2.sec, EV_NONE, ST_INCOMPLETE, 32'd0);
        end
      end else if (b == CH_CR) begin
        push.count = 2'd0;
      end else begin
        push.count = 2'd1;
        push.first = mk_res(c1.ob, c1.sec, EV_NONE, ST_INCOMPLETE, 32'd0);
      end
      // Flag the final result of the byte
      if (push.count == 2'd1) begin
        push.first.last = 1'b1;
      end
      if (push.count == 2'd2) begin
        push.second.last = 1'b1;
      end
    end
  end

  // Hold parser state and the length register
  always_ff @(posedge clk) begin
    if (rst) begin
      st             <= ST_RESET;
      accum          <= '0;
      chosen         <= '0;
      chosen_invalid <= 1'b0;
      remaining      <= '0;
      max_body_size  <= MAX_BODY_RESET;
    end else begin
      st             <= st_next;
      accum          <= accum_next;
      chosen         <= chosen_next;
      chosen_invalid <= chosen_invalid_next;
      remaining      <= remaining_next;
      if (cfg_write) begin
        max_body_size <= cfg_data;
      end
    end
  end

endmodule

`default_nettype wire

>>> src/hrf_queue.sv
// Short result queue between the framer front and back.
// Depends on hrf_pkg; takes up to two results a cycle, gives one.
`default_nettype none

module hrf_queue (
  input  logic           clk,
  input  logic           rst,
  input  hrf_pkg::push_t push,
  input  logic           pop,
  output hrf_pkg::res_t  head,
  output logic           head_valid,
  output logic           room
);
  import hrf_pkg::*;

  localparam int PTR_W = $clog2(Q_DEPTH);

  res_t             mem [Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [PTR_W:0]   count;

  assign head       = mem[rd_ptr];
  assign head_valid = (count != '0);
  assign room       = (count <= (PTR_W + 1)'(Q_DEPTH - 2));

  // Store pushed results
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      mem[wr_ptr + PTR_W'(1)] <= push.second;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(push.count);
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      count <= count + (PTR_W + 1)'(push.count) - (PTR_W + 1)'(pop);
    end
  end

endmodule

`default_nettype wire

>>> src/hrf_back.sv
// Back of the framer: output register that presents results one per transfer.
// Depends on hrf_pkg; drains hrf_queue.
`default_nettype none

module hrf_back (
  input  logic          clk,
  input  logic          rst,
  input  hrf_pkg::res_t head,
  input  logic          head_valid,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_stall,
  output hrf_pkg::res_t out_data
);
  import hrf_pkg::*;

  assign pop = head_valid && (!out_valid || !out_stall);

  // Load the next result when the register is free or being taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid <= head_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data <= head;
    end
  end

endmodule

`default_nettype wire

>>> src/http_request_framer.sv
// HTTP request framer: one byte per cycle in while in_stall is low, one tagged result
// per cycle out while out_stall is low. A byte's first result passes the queue write,
// then the output register. A byte that makes two results is absorbed by the four-entry
// result queue, which raises in_stall once it holds more than two results.
// Reset (rst, synchronous): parser to request line, queue empty, max_body_size to 1048576.
`default_nettype none

module http_request_framer #(
  parameter int LENGTH_BITS = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  hrf_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output hrf_pkg::res_t out_data,
  input  logic          cfg_write,
  input  logic [31:0]   cfg_data
);
  import hrf_pkg::*;

  push_t push;
  res_t  head;
  logic  head_valid;
  logic  room;
  logic  pop;

  hrf_front #(.LENGTH_BITS(LENGTH_BITS)) u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .cfg_write(cfg_write), .cfg_data(cfg_data), .room(room), .push(push)
  );

  hrf_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .pop(pop), .head(head),
    .head_valid(head_valid), .room(room)
  );

  hrf_back u_back (
    .clk(clk), .rst(rst), .head(head), .head_valid(head_valid), .pop(pop),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

endmodule

`default_nettype wire

>>> src/hrf_checker.sv
// Port-level checks for the HTTP request framer, bound to the top level.
// Depends on hrf_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module hrf_checker (
  input logic          clk,
  input logic          rst,
  input logic          out_valid,
  input logic          out_stall,
  input hrf_pkg::res_t out_data
);
  import hrf_pkg::*;

  // Hold a stalled result
  `HRF_ASSERT_IMPL(a_out_hold, out_valid && out_stall, ##1 out_valid, "result dropped while stalled")

  // Error event carries error status
  `HRF_ASSERT_IMPL(a_err_status, out_valid && out_data.event_res == EV_ERROR, out_data.status == ST_ERROR, "error event without error status")

  // Completion event carries complete status
  `HRF_ASSERT_IMPL(a_done_status, out_valid && out_data.event_res == EV_COMPLETE, out_data.status == ST_COMPLETE, "complete event without complete status")

  // Body length only on headers done
  `HRF_ASSERT_IMPL(a_blen, out_valid && out_data.body_length != 32'd0, out_data.event_res == EV_HDRS_END, "body length outside headers done")

  // Empty results only after the request has ended
  `HRF_ASSERT_IMPL(a_empty_res, out_valid && out_data.section == SEC_NONE && out_data.event_res == EV_NONE, out_data.status != ST_INCOMPLETE, "empty result while incomplete")

endmodule

bind http_request_framer hrf_checker u_hrf_checker (
  .clk(clk), .rst(rst), .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);

`default_nettype wire

>>> verif/tb_top.sv
// Self-checking testbench for http_request_framer: random and directed requests
// against a built-in byte classifier. Depends on hrf_pkg and the framer RTL only.
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import hrf_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_HOLD = 80;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  res_t out_data;
  logic cfg_write = 1'b0;
  logic [31:0] cfg_data = '0;

  http_request_framer dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_write(cfg_write), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stimulus and expectation stores
  in_t byte_queue[$];
  res_t pending_tags[$];
  res_t step_tags[$];
  int errors = 0;
  int cycles = 0;
  bit idle_on = 1'b1;
  bit hold_req = 1'b0;
  bit hold_used = 1'b0;
  int hold_left = 0;
  int stall_left = 0;
  int send_gap = 0;
  logic took = 1'b0;

  // Classifier state
  phase_t fr_phase;
  bit fr_cr;
  int fr_spaces;
  bit fr_empty;
  bit fr_colon;
  int fr_match;
  logic [2:0] fr_vsub;
  bit fr_neg;
  logic [63:0] fr_accum;
  logic [63:0] fr_len;
  bit fr_len_bad;
  logic [63:0] fr_body_left;
  logic [31:0] fr_max_body;
  string cl_text = "content-length";

  function automatic void clear_line_state();
    fr_empty = 1'b1;
    fr_colon = 1'b0;
    fr_match = 0;
    fr_vsub = VS_IDLE;
    fr_neg = 1'b0;
    fr_accum = '0;
  endfunction

  function automatic void reset_framer();
    fr_phase = PH_LINE;
    fr_cr = 1'b0;
    fr_spaces = 0;
    clear_line_state();
    fr_len = '0;
    fr_len_bad = 1'b0;
    fr_body_left = '0;
  endfunction

  function automatic void add_tag(logic [7:0] b, logic [2:0] sec, logic [2:0] ev,
                                  logic [31:0] blen);
    res_t r;
    r.out_byte = b;
    r.section = sec;
    r.event_res = ev;
    r.status = (fr_phase == PH_DONE) ? ST_COMPLETE :
               (fr_phase == PH_ERR) ? ST_ERROR : ST_INCOMPLETE;
    r.body_length = blen;
    r.last = 1'b0;
    step_tags.push_back(r);
  endfunction

  function automatic void add_digit(int d);
    logic [63:0] cap;
    cap = 64'd1 << 32;
    if (fr_accum > (cap - d) / 10) fr_accum = cap;
    else fr_accum = fr_accum * 10 + d;
  endfunction

  function automatic void value_char(logic [7:0] b);
    bit ws;
    bit dig;
    ws = (b == CH_SPACE) || (b >= 8'd9 && b <= 8'd13);
    dig = (b >= "0" && b <= "9");
    case (fr_vsub)
      VS_START: begin
        if (ws) begin
        end else if (b == CH_PLUS || b == CH_MINUS) begin
          fr_neg = (b == CH_MINUS);
          fr_vsub = VS_SIGN;
        end else if (dig) begin
          add_digit(b - "0");
          fr_vsub = VS_DIGITS;
        end else fr_vsub = VS_BAD;
      end
      VS_SIGN: begin
        if (dig) begin
          add_digit(b - "0");
          fr_vsub = VS_DIGITS;
        end else fr_vsub = VS_BAD;
      end
      VS_DIGITS: begin
        if (dig) add_digit(b - "0");
        else fr_vsub = VS_END;
      end
      default: ;
    endcase
  endfunction

  // Classify one ordinary byte of the request line or a header line
  function automatic void line_char(logic [7:0] b);
    logic [7:0] low;
    if (fr_phase == PH_LINE) begin
      if (b == CH_SPACE && fr_spaces < 2) begin
        fr_spaces++;
        add_tag(b, SEC_DELIM, EV_NONE, 0);
      end else add_tag(b, SEC_METHOD + 3'(fr_spaces), EV_NONE, 0);
      return;
    end
    fr_empty = 1'b0;
    if (!fr_colon) begin
      if (b == CH_COLON) begin
        fr_colon = 1'b1;
        add_tag(b, SEC_DELIM, EV_NONE, 0);
        return;
      end
      low = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
      if (fr_match < MATCH_LEN && low == cl_text[fr_match]) fr_match++;
      else fr_match = MATCH_FAIL;
      add_tag(low, SEC_NAME, EV_NONE, 0);
      return;
    end
    if (fr_vsub == VS_IDLE) begin
      if (b == CH_SPACE) begin
        add_tag(b, SEC_DELIM, EV_NONE, 0);
        return;
      end
      fr_vsub = VS_START;
    end
    value_char(b);
    add_tag(b, SEC_VALUE, EV_NONE, 0);
  endfunction

  function automatic void close_line();
    bit digits;
    if (fr_phase == PH_LINE) begin
      if (fr_spaces < 2) begin
        fr_phase = PH_ERR;
        add_tag(CH_LF, SEC_DELIM, EV_ERROR, 0);
      end else begin
        fr_phase = PH_HDR;
        clear_line_state();
        add_tag(CH_LF, SEC_DELIM, EV_REQ_OK, 0);
      end
      return;
    end
    if (fr_empty) begin
      if (fr_len_bad || fr_len > {32'd0, fr_max_body}) begin
        fr_phase = PH_ERR;
        add_tag(CH_LF, SEC_DELIM, EV_ERROR, 0);
      end else if (fr_len == 0) begin
        fr_phase = PH_DONE;
        add_tag(CH_LF, SEC_DELIM, EV_HDRS_END, 0);
        add_tag(8'd0, SEC_NONE, EV_COMPLETE, 0);
      end else begin
        fr_phase = PH_BODY;
        fr_body_left = fr_len;
        add_tag(CH_LF, SEC_DELIM, EV_HDRS_END, fr_len[31:0]);
      end
      return;
    end
    if (!fr_colon) begin
      fr_phase = PH_ERR;
      add_tag(CH_LF, SEC_DELIM, EV_ERROR, 0);
      return;
    end
    if (fr_match == MATCH_LEN) begin
      digits = (fr_vsub == VS_DIGITS || fr_vsub == VS_END);
      fr_len_bad = !digits || fr_accum >= (64'd1 << 32) || (fr_neg && fr_accum != 0);
      fr_len = fr_len_bad ? 64'd0 : fr_accum;
    end
    clear_line_state();
    add_tag(CH_LF, SEC_DELIM, EV_HDR_OK, 0);
  endfunction

  // Work out the tags that one transferred item causes
  function automatic void frame_byte(in_t it);
    logic [7:0] b;
    b = it.data_byte;
    step_tags.delete();
    if (it.mode) begin
      reset_framer();
      return;
    end
    if (fr_phase == PH_BODY) begin
      fr_body_left--;
      if (fr_body_left == 0) begin
        fr_phase = PH_DONE;
        add_tag(b, SEC_BODY, EV_COMPLETE, 0);
      end else add_tag(b, SEC_BODY, EV_NONE, 0);
    end else if (fr_phase == PH_DONE || fr_phase == PH_ERR) begin
      add_tag(8'd0, SEC_NONE, EV_NONE, 0);
    end else if (fr_cr) begin
      if (b == CH_LF) begin
        fr_cr = 1'b0;
        close_line();
      end else begin
        line_char(CH_CR);
        if (b == CH_CR) fr_cr = 1'b1;
        else begin
          fr_cr = 1'b0;
          line_char(b);
        end
      end
    end else if (b == CH_CR) fr_cr = 1'b1;
    else line_char(b);
    if (step_tags.size() > 0) step_tags[step_tags.size() - 1].last = 1'b1;
    foreach (step_tags[i]) pending_tags.push_back(step_tags[i]);
  endfunction

  // Note each transfer on the input side and predict its tags
  always @(posedge clk) begin
    took <= in_valid && !in_stall && !rst;
    if (!rst && in_valid && !in_stall) frame_byte(in_data);
  end

  // Driver: advance to the next item after a transfer, with idle bursts
  always @(negedge clk) begin
    if (!rst && (!in_valid || took)) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (byte_queue.size() > 0) begin
        if (idle_on && $urandom_range(0, 5) == 0) begin
          send_gap <= $urandom_range(0, 2);
          in_valid <= 1'b0;
        end else begin
          in_valid <= 1'b1;
          in_data <= byte_queue.pop_front();
        end
      end else in_valid <= 1'b0;
    end
  end

  // Receiver: one long hold on request, otherwise short stall bursts
  always @(negedge clk) begin
    if (hold_req && !hold_used) begin
      hold_used <= 1'b1;
      hold_left <= LONG_HOLD;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      stall_left <= $urandom_range(0, 2);
      out_stall <= 1'b1;
    end else out_stall <= 1'b0;
  end

  // Monitor: compare each transfer with the oldest expected tag
  always @(posedge clk) begin
    res_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending_tags.size() == 0) begin
        errors++;
        $display("%0t: unexpected result %h", $time, out_data);
      end else begin
        e = pending_tags.pop_front();
        if (out_data.out_byte !== e.out_byte) begin
          errors++;
          $display("%0t: out_byte expected %h actual %h", $time, e.out_byte, out_data.out_byte);
        end
        if (out_data.section !== e.section) begin
          errors++;
          $display("%0t: section expected %0d actual %0d", $time, e.section, out_data.section);
        end
        if (out_data.event_res !== e.event_res) begin
          errors++;
          $display("%0t: event_res expected %0d actual %0d", $time, e.event_res,
                   out_data.event_res);
        end
        if (out_data.status !== e.status) begin
          errors++;
          $display("%0t: status expected %0d actual %0d", $time, e.status, out_data.status);
        end
        if (out_data.body_length !== e.body_length) begin
          errors++;
          $display("%0t: body_length expected %0d actual %0d", $time, e.body_length,
                   out_data.body_length);
        end
        if (out_data.last !== e.last) begin
          errors++;
          $display("%0t: last expected %b actual %b", $time, e.last, out_data.last);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic put_byte(logic [7:0] b);
    in_t it;
    it.mode = 1'b0;
    it.data_byte = b;
    byte_queue.push_back(it);
  endtask

  task automatic put_text(string s);
    foreach (s[i]) put_byte(s[i]);
  endtask

  task automatic put_restart();
    in_t it;
    it.mode = 1'b1;
    it.data_byte = 8'($urandom_range(0, 255));
    byte_queue.push_back(it);
  endtask

  task automatic put_token(int n, bit upper);
    for (int i = 0; i < n; i++)
      put_byte(upper ? 8'($urandom_range("A", "Z")) : 8'($urandom_range("!", "~")));
  endtask

  // Wait for the sender to run dry and every expected tag to arrive
  task automatic drain();
    while (byte_queue.size() > 0 || in_valid) @(posedge clk);
    while (pending_tags.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_max_body(logic [31:0] v);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_write <= 1'b0;
    fr_max_body = v;
  endtask

  // One request, mostly well formed, with random content and occasional damage
  task automatic put_request();
    int body_len;
    int kind;
    string cl_name;
    put_restart();
    put_token($urandom_range(1, 6), 1'b1);
    if ($urandom_range(0, 19) != 0) put_byte(CH_SPACE);
    put_byte("/");
    put_token($urandom_range(0, 8), 1'b0);
    put_byte(CH_SPACE);
    put_text("HTTP/1.1");
    if ($urandom_range(0, 15) == 0) put_text(" x");
    put_text("\r\n");
    body_len = 0;
    repeat ($urandom_range(0, 3)) begin
      kind = $urandom_range(0, 9);
      if (kind < 5) begin
        case ($urandom_range(0, 4))
          0: cl_name = "Content-Length";
          1: cl_name = "CONTENT-LENGTH";
          2: cl_name = "content-lengthx";
          3: cl_name = "content-lengt";
          default: cl_name = "content-length";
        endcase
        put_text(cl_name);
        put_byte(CH_COLON);
        repeat ($urandom_range(0, 2)) put_byte(CH_SPACE);
        if ($urandom_range(0, 3) == 0) put_byte(8'h09);
        body_len = $urandom_range(0, 12);
        case ($urandom_range(0, 9))
          0: put_text("-0");
          1: put_text($sformatf("-%0d", body_len + 1));
          2: put_text("abc");
          3: put_text("99999999999");
          4: put_text($sformatf("+%0d", body_len));
          5: put_text($sformatf("%0dz9", body_len));
          default: put_text($sformatf("%0d", body_len));
        endcase
      end else if (kind == 5) begin
        put_token($urandom_range(1, 5), 1'b1);
      end else begin
        put_token($urandom_range(1, 6), 1'b1);
        put_byte(CH_COLON);
        put_byte(CH_SPACE);
        put_token($urandom_range(0, 6), 1'b0);
      end
      put_text("\r\n");
    end
    put_text("\r\n");
    repeat (body_len + $urandom_range(0, 2)) put_byte(8'($urandom_range(0, 255)));
    if ($urandom_range(0, 9) == 0)
      repeat ($urandom_range(1, 10)) put_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic random_phase(int n);
    int start;
    start = byte_queue.size();
    while (byte_queue.size() - start < n) put_request();
  endtask

  initial begin
    fr_max_body = MAX_BODY_RESET;
    reset_framer();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: body, zero length, split errors, held CR, value forms
    write_max_body(MAX_BODY_RESET);
    put_text("GET / HTTP/1.1\r\nContent-Length: 3\r\n\r\nab\rQ");
    put_restart();
    put_text("P /\xff\x00 v\r\nA:\r\n\r\n");
    put_restart();
    put_text("X\r\n");
    put_restart();
    put_text("A\rB C\r\r\n\nh\n: \t-0\r\n\r\n");
    put_restart();
    put_text("M T V\r\ncontent-length: 4294967296\r\n\r\n");
    put_restart();
    put_text("M T V\r\nnocolon\r\n");
    random_phase(310);
    drain();

    // Zero limit, with a long receiver hold while the sender keeps going
    write_max_body(32'd0);
    hold_req = 1'b1;
    random_phase(310);
    drain();

    write_max_body(32'hFFFF_FFFF);
    put_restart();
    put_text("M T V\r\ncontent-length: 4294967295\r\n\r\nxyz");
    random_phase(310);
    drain();

    write_max_body(32'd7);
    random_phase(310);
    drain();

    // Last part runs without idling
    write_max_body(MAX_BODY_RESET);
    idle_on = 1'b0;
    random_phase(310);
    drain();

    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

`default_nettype wire
